// File: design/sts_pkg.sv
`default_nettype none

package sts_pkg;

  localparam int M_DATA_W = 24;
  localparam logic [7:0] LEN_FULL = 8'h80;
  localparam logic [3:0] ERR_NULL_NIB = 4'h4;

  typedef enum logic [1:0] {
    FUNC_REQ   = 2'd0,
    FUNC_DONE  = 2'd1,
    FUNC_ALARM = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REFUSE = 2'd1,
    KIND_START  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  chan;
    logic [3:0]  err;
    logic [6:0]  olc;
    logic [6:0]  ilc;
    logic        irq;
    logic        last;
  } res_t;

  function automatic logic [6:0] len_code(input logic [7:0] len);
    return (len == LEN_FULL) ? 7'd0 : len[6:0];
  endfunction

endpackage

`default_nettype wire

// File: design/sts_outbuf.sv
`default_nettype none

module sts_outbuf
  import sts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [1:0] push_cnt_i,
  input  wire res_t       push_res_i [2],
  input  wire logic       pop_ready_i,
  output logic            room_o,
  output logic            head_valid_o,
  output res_t            head_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       e_q [2];

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = e_q[0];
  assign room_o       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) begin
      cnt_d = push_cnt_i;
    end else if (head_valid_o && pop_ready_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // shift the second word forward after a pop
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      e_q[0] <= push_res_i[0];
      e_q[1] <= push_res_i[1];
    end else if (head_valid_o && pop_ready_i) begin
      e_q[0] <= e_q[1];
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");
  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> (!e_q[0].last && e_q[1].last))
    else $error("last flag misplaced in result pair");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push without room");
`endif

endmodule

`default_nettype wire

// File: design/sts_core.sv
`default_nettype none

module sts_core
  import sts_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int TIME_BITS    = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 go_i,
  input  wire func_e                func_i,
  input  wire logic [1:0]           chan_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [TIME_BITS-1:0] delay_i,
  input  wire logic [7:0]           out_len_i,
  input  wire logic [7:0]           in_len_i,
  input  wire logic                 want_irq_i,
  input  wire logic [3:0]           status_nibble_i,
  input  wire logic                 com_error_i,
  output res_t                      res_o [2],
  output logic [1:0]                res_cnt_o
);

  localparam int CW  = $clog2(NUM_CHANNELS);
  localparam int CIW = CW + 1;

  logic                 busy_q, busy_d;
  logic [CW-1:0]        act_q, act_d;
  logic                 act_irq_q, act_irq_d;
  logic [NUM_CHANNELS-1:0] pend_q, pend_d;
  logic [TIME_BITS-1:0] done_q [NUM_CHANNELS];
  logic [TIME_BITS-1:0] done_d [NUM_CHANNELS];
  logic [TIME_BITS-1:0] fire_q [NUM_CHANNELS];
  logic [7:0]           olen_q [NUM_CHANNELS];
  logic [7:0]           ilen_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] sirq_q;

  logic                 ch_ok;
  logic [CW-1:0]        ci;
  logic [TIME_BITS-1:0] fire;
  logic                 refuse;
  logic                 start_now;
  logic                 park;
  logic [3:0]           err_code;

  logic [NUM_CHANNELS-1:0] due;
  logic [CW-1:0]        scan_from;
  logic [CIW-1:0]       scan_sum;
  logic                 scan_found;
  logic [CW-1:0]        scan_pick;

  logic                 lead_v;
  res_t                 lead;
  logic                 start_v;
  logic                 start_slot;
  logic [CW-1:0]        start_ch;
  logic [7:0]           start_olen;
  logic [7:0]           start_ilen;
  logic                 start_irq;
  res_t                 start_res;

  assign ch_ok     = (32'(chan_i) < NUM_CHANNELS);
  assign ci        = CW'(chan_i);
  assign refuse    = !ch_ok || pend_q[ci] || (busy_q && (act_q == ci));
  assign fire      = (delay_i == '0) ? now_i : (delay_i + done_q[ci]);
  assign start_now = !(now_i < fire) && !busy_q;
  assign err_code  = !com_error_i ? 4'd0 :
                     (status_nibble_i == 4'd0) ? ERR_NULL_NIB : status_nibble_i;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      due[c] = pend_q[c] && !(now_i < fire_q[c]);
    end
  end

  // rotate the pick to start after the finished channel
  assign scan_from = !busy_q ? '0 :
                     (act_q == CW'(NUM_CHANNELS - 1)) ? '0 : (act_q + CW'(1));

  always_comb begin
    scan_found = 1'b0;
    scan_pick  = '0;
    scan_sum   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      scan_sum = CIW'(scan_from) + CIW'(i);
      if (scan_sum >= CIW'(NUM_CHANNELS)) begin
        scan_sum = scan_sum - CIW'(NUM_CHANNELS);
      end
      if (!scan_found && due[scan_sum[CW-1:0]]) begin
        scan_found = 1'b1;
        scan_pick  = scan_sum[CW-1:0];
      end
    end
  end

  always_comb begin
    busy_d     = busy_q;
    act_d      = act_q;
    act_irq_d  = act_irq_q;
    pend_d     = pend_q;
    done_d     = done_q;
    park       = 1'b0;
    lead_v     = 1'b0;
    lead       = '0;
    start_v    = 1'b0;
    start_slot = 1'b0;
    start_ch   = ci;
    if (go_i) begin
      case (func_i)
        FUNC_REQ: begin
          lead_v    = 1'b1;
          lead.chan = chan_i;
          if (refuse) begin
            lead.kind = KIND_REFUSE;
          end else begin
            lead.kind = KIND_ACCEPT;
            if (start_now) begin
              start_v = 1'b1;
            end else begin
              park       = 1'b1;
              pend_d[ci] = 1'b1;
            end
          end
        end
        FUNC_DONE: begin
          if (busy_q) begin
            lead_v        = 1'b1;
            lead.kind     = KIND_DONE;
            lead.chan     = 2'(act_q);
            lead.err      = err_code;
            lead.irq      = act_irq_q;
            done_d[act_q] = now_i;
            busy_d        = 1'b0;
          end
          if (scan_found) begin
            start_v           = 1'b1;
            start_slot        = 1'b1;
            start_ch          = scan_pick;
            pend_d[scan_pick] = 1'b0;
          end
        end
        FUNC_ALARM: begin
          if (ch_ok && pend_q[ci] && !busy_q) begin
            start_v    = 1'b1;
            start_slot = 1'b1;
            pend_d[ci] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    start_olen = start_slot ? olen_q[start_ch] : out_len_i;
    start_ilen = start_slot ? ilen_q[start_ch] : in_len_i;
    start_irq  = start_slot ? sirq_q[start_ch] : want_irq_i;
    if (start_v) begin
      busy_d    = 1'b1;
      act_d     = start_ch;
      act_irq_d = start_irq;
    end
  end

  always_comb begin
    start_res      = '0;
    start_res.kind = KIND_START;
    start_res.chan = 2'(start_ch);
    start_res.olc  = len_code(start_olen);
    start_res.ilc  = len_code(start_ilen);
    start_res.irq  = start_irq;
    res_o[0]       = '0;
    res_o[1]       = '0;
    if (lead_v) begin
      res_o[0]      = lead;
      res_o[1]      = start_res;
      res_o[0].last = !start_v;
      res_o[1].last = 1'b1;
      res_cnt_o     = start_v ? 2'd2 : 2'd1;
    end else begin
      res_o[0]      = start_res;
      res_o[0].last = 1'b1;
      res_cnt_o     = start_v ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      act_q     <= '0;
      act_irq_q <= 1'b0;
      pend_q    <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        done_q[c] <= '0;
      end
    end else begin
      busy_q    <= busy_d;
      act_q     <= act_d;
      act_irq_q <= act_irq_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // park the request in its channel slot
  always_ff @(posedge clk_i) begin
    if (park) begin
      fire_q[ci] <= fire;
      olen_q[ci] <= out_len_i;
      ilen_q[ci] <= in_len_i;
      sirq_q[ci] <= want_irq_i;
    end
  end

`ifndef ASSERT_OFF
  a_active_not_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pend_q[act_q])
    else $error("active channel also holds a parked slot");
  a_req_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && (func_i == FUNC_REQ)) |-> (res_cnt_o != 2'd0))
    else $error("request gave no result");
  a_alarm_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && (func_i == FUNC_ALARM)) |-> (res_cnt_o != 2'd2))
    else $error("alarm gave two results");
`endif

endmodule

`default_nettype wire

// File: design/serial_transfer_scheduler_top.sv
`default_nettype none
// Flow: an accepted word is registered, then processed once the result buffer has room;
// its result words are written into the result buffer and presented from there.
// Throughput: one input word per cycle while each gives at most one result and the
// output is ready; a word with two results fills the two-entry result buffer.
// Reset: asynchronous, active low; bus idle, no parked slots, completion times zero.

module serial_transfer_scheduler_top
  import sts_pkg::*;
#(
  parameter int NUM_CHANNELS = 4,
  parameter int TIME_BITS    = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // chan, now, delay, out_len, in_len, want_irq, status_nibble, com_error, zero fill
  input  wire logic [((24 + 2 * TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // func
  input  wire logic [1:0]          s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // out_chan, err_code, out_len_code, in_len_code, irq_enable, zero fill
  output logic [M_DATA_W-1:0]      m_axis_tdata_o,
  // kind
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int NOW_LO      = 2;
  localparam int DLY_LO      = NOW_LO + TIME_BITS;
  localparam int OLEN_LO     = DLY_LO + TIME_BITS;
  localparam int ILEN_LO     = OLEN_LO + 8;
  localparam int IRQ_BIT     = ILEN_LO + 8;
  localparam int NIB_LO      = IRQ_BIT + 1;
  localparam int CERR_BIT    = NIB_LO + 4;

  logic                 in_v_q, in_v_d;
  func_e                func_q;
  logic [1:0]           chan_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] delay_q;
  logic [7:0]           out_len_q;
  logic [7:0]           in_len_q;
  logic                 want_irq_q;
  logic [3:0]           nib_q;
  logic                 cerr_q;

  logic                 room;
  logic                 go;
  logic                 in_take;
  res_t                 res [2];
  logic [1:0]           res_cnt;
  res_t                 head;

  assign go              = in_v_q && room;
  assign s_axis_tready_o = !in_v_q || room;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_v_d = in_v_q;
    if (in_take) begin
      in_v_d = 1'b1;
    end else if (go) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q     <= func_e'(s_axis_tuser_i);
      chan_q     <= s_axis_tdata_i[1:0];
      now_q      <= s_axis_tdata_i[NOW_LO +: TIME_BITS];
      delay_q    <= s_axis_tdata_i[DLY_LO +: TIME_BITS];
      out_len_q  <= s_axis_tdata_i[OLEN_LO +: 8];
      in_len_q   <= s_axis_tdata_i[ILEN_LO +: 8];
      want_irq_q <= s_axis_tdata_i[IRQ_BIT];
      nib_q      <= s_axis_tdata_i[NIB_LO +: 4];
      cerr_q     <= s_axis_tdata_i[CERR_BIT];
    end
  end

  sts_core #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .go_i           (go),
    .func_i         (func_q),
    .chan_i         (chan_q),
    .now_i          (now_q),
    .delay_i        (delay_q),
    .out_len_i      (out_len_q),
    .in_len_i       (in_len_q),
    .want_irq_i     (want_irq_q),
    .status_nibble_i(nib_q),
    .com_error_i    (cerr_q),
    .res_o          (res),
    .res_cnt_o      (res_cnt)
  );

  sts_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (go),
    .push_cnt_i  (res_cnt),
    .push_res_i  (res),
    .pop_ready_i (m_axis_tready_i),
    .room_o      (room),
    .head_valid_o(m_axis_tvalid_o),
    .head_o      (head)
  );

  assign m_axis_tdata_o = {3'b000, head.irq, head.ilc, head.olc, head.err, head.chan};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire
